FILE: design/fwrl_pkg.sv
// ----------------------------------------------------------------------------
// Fixed-window rate limiter package
// Widths, codes and shared types of the rate limiter block.
// ----------------------------------------------------------------------------
package fwrl_pkg;

  localparam int IDX_W      = 8;
  localparam int TS_W       = 32;
  localparam int WINDOW_W   = 31;
  localparam int LIMIT_W    = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam int CLIENTS_DEFAULT = 256;
  localparam int INDEX_SPAN      = 2 ** IDX_W;

  localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(1000);
  localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = LIMIT_W'(10);

  localparam logic OP_REQUEST = 1'b0;
  localparam logic OP_CLEAR   = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_TICKS  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_REQUEST_LIMIT = 1'b1;

  typedef struct packed {
    logic [LIMIT_W-1:0] count;
    logic [TS_W-1:0]    start;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic             clr;
    logic [IDX_W-1:0] addr;
    entry_t           entry;
  } wr_t;

  typedef struct packed {
    logic   write;
    logic   allowed;
    logic   new_window;
    entry_t entry;
  } dec_t;

endpackage

FILE: design/fwrl_if.sv
// ----------------------------------------------------------------------------
// Fixed-window rate limiter channels
// Valid/ready channels for request items, result items and register writes.
// ----------------------------------------------------------------------------
interface fwrl_in_if;
  logic                      valid;
  logic                      ready;
  logic                      opcode;
  logic [fwrl_pkg::IDX_W-1:0] client_index;
  logic [fwrl_pkg::TS_W-1:0]  timestamp;

  modport source (output valid, opcode, client_index, timestamp, input ready);
  modport sink   (input valid, opcode, client_index, timestamp, output ready);
endinterface

interface fwrl_out_if;
  logic valid;
  logic ready;
  logic allowed;
  logic new_window;

  modport source (output valid, allowed, new_window, input ready);
  modport sink   (input valid, allowed, new_window, output ready);
endinterface

interface fwrl_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [fwrl_pkg::CFG_IDX_W-1:0]  index;
  logic [fwrl_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: design/fixed_window_rate_limiter_unit.sv
// ----------------------------------------------------------------------------
// Fixed-window rate limiter unit
// Per-client request counting within fixed time windows.
// ----------------------------------------------------------------------------
// Request and clear items enter on in_ch; each request gives one result item
// on out_ch (allowed, new_window), a clear gives none. Registers are written
// on cfg_ch: index 0 is the window length in ticks, index 1 the request
// limit. The write channel is always ready; it is to be used only while idle,
// which the block itself does not enforce. An accepted item reads its client
// entry from the table memory at the accept edge; in the decision stage the
// decision is made, the entry written back and the result registered as the
// item leaves that stage. Back-to-back items on one client are served through
// a forwarding path, so one item is taken every cycle while out_ch does not
// stall, set by the single read-modify-write of the table memory per item.
// When out_ch stalls, the item in the decision stage holds and in_ch is
// ready only as that stage empties. Reset returns the registers to 1000 and
// 10 and marks every client entry empty at once through per-entry valid
// bits; a clear item marks every entry empty the same way.
// ----------------------------------------------------------------------------
module fixed_window_rate_limiter_unit #(
  parameter int CLIENTS = fwrl_pkg::CLIENTS_DEFAULT
) (
  input logic          clk,
  input logic          rst_n,
  fwrl_in_if.sink      in_ch,
  fwrl_out_if.source   out_ch,
  fwrl_cfg_if.sink     cfg_ch
);

  localparam int DEPTH = (CLIENTS < fwrl_pkg::INDEX_SPAN) ? CLIENTS : fwrl_pkg::INDEX_SPAN;

  logic [fwrl_pkg::WINDOW_W-1:0] window_r;
  logic [fwrl_pkg::LIMIT_W-1:0]  limit_r;

  logic                       s1_valid_r;
  logic                       s1_op_r;
  logic                       s1_inrange_r;
  logic [fwrl_pkg::IDX_W-1:0] s1_idx_r;
  logic [fwrl_pkg::TS_W-1:0]  s1_ts_r;

  logic out_valid_r;
  logic out_allowed_r;
  logic out_new_window_r;

  logic             in_fire;
  logic             s1_go;
  fwrl_pkg::wr_t    wr;
  fwrl_pkg::entry_t rd_entry;
  fwrl_pkg::dec_t   dec;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= fwrl_pkg::WINDOW_RESET;
      limit_r  <= fwrl_pkg::LIMIT_RESET;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        fwrl_pkg::CFG_WINDOW_TICKS:  window_r <= cfg_ch.data[fwrl_pkg::WINDOW_W-1:0];
        fwrl_pkg::CFG_REQUEST_LIMIT: limit_r  <= cfg_ch.data[fwrl_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  assign s1_go       = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_go;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r      <= in_ch.opcode;
      s1_idx_r     <= in_ch.client_index;
      s1_ts_r      <= in_ch.timestamp;
      s1_inrange_r <= (32'(in_ch.client_index) < CLIENTS);
    end
  end

  fwrl_table #(
    .DEPTH (DEPTH)
  ) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_fire),
    .rd_addr  (in_ch.client_index),
    .wr       (wr),
    .rd_entry (rd_entry)
  );

  fwrl_decide u_decide (
    .entry         (rd_entry),
    .now           (s1_ts_r),
    .window_ticks  (window_r),
    .request_limit (limit_r),
    .dec           (dec)
  );

  always_comb begin
    wr.en    = s1_go && (s1_op_r == fwrl_pkg::OP_REQUEST) && s1_inrange_r && dec.write;
    wr.clr   = s1_go && (s1_op_r == fwrl_pkg::OP_CLEAR);
    wr.addr  = s1_idx_r;
    wr.entry = dec.entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && (s1_op_r == fwrl_pkg::OP_REQUEST)) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && (s1_op_r == fwrl_pkg::OP_REQUEST)) begin
      out_allowed_r    <= s1_inrange_r && dec.allowed;
      out_new_window_r <= s1_inrange_r && dec.new_window;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.allowed    = out_allowed_r;
  assign out_ch.new_window = out_new_window_r;

  a_wr_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr.en && wr.clr))
    else $error("Table write and clear in the same cycle.");

  a_in_to_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> s1_valid_r)
    else $error("Accepted item did not reach the decision stage.");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_go) |=> (s1_valid_r && $stable(s1_ts_r) && $stable(s1_idx_r)))
    else $error("Stalled item in the decision stage was lost or changed.");

  a_req_result: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && (s1_op_r == fwrl_pkg::OP_REQUEST)) |=> out_valid_r)
    else $error("Request left the decision stage without a result item.");

endmodule

FILE: design/fwrl_table.sv
// ----------------------------------------------------------------------------
// Fixed-window rate limiter client table
// Entry memory with registered read, per-entry valid bits and write forwarding.
// ----------------------------------------------------------------------------
module fwrl_table #(
  parameter int DEPTH = fwrl_pkg::CLIENTS_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       rd_en,
  input  logic [fwrl_pkg::IDX_W-1:0] rd_addr,
  input  fwrl_pkg::wr_t              wr,
  output fwrl_pkg::entry_t           rd_entry
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  fwrl_pkg::entry_t mem [DEPTH];
  fwrl_pkg::entry_t rd_q;
  fwrl_pkg::entry_t fwd_entry_r;
  logic [DEPTH-1:0] valid_r;
  logic             rd_valid_r;
  logic             fwd_hit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr.clr) begin
      valid_r <= '0;
    end else if (wr.en) begin
      valid_r[wr.addr[AW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr[AW-1:0]] <= wr.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q <= mem[rd_addr[AW-1:0]];
    end
  end

  // A write or clear at the read edge is not seen by the array read, so it is
  // captured here instead.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r  <= 1'b0;
      rd_valid_r <= 1'b0;
    end else if (rd_en) begin
      fwd_hit_r  <= wr.en && (wr.addr == rd_addr);
      rd_valid_r <= !wr.clr && valid_r[rd_addr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_entry_r <= wr.entry;
    end
  end

  always_comb begin
    if (fwd_hit_r) begin
      rd_entry = fwd_entry_r;
    end else if (rd_valid_r) begin
      rd_entry = rd_q;
    end else begin
      rd_entry.count = '0;
      rd_entry.start = rd_q.start;
    end
  end

endmodule

FILE: design/fwrl_decide.sv
// ----------------------------------------------------------------------------
// Fixed-window rate limiter decision
// Window expiry check, limit compare and the updated entry for one request.
// ----------------------------------------------------------------------------
module fwrl_decide (
  input  fwrl_pkg::entry_t              entry,
  input  logic [fwrl_pkg::TS_W-1:0]     now,
  input  logic [fwrl_pkg::WINDOW_W-1:0] window_ticks,
  input  logic [fwrl_pkg::LIMIT_W-1:0]  request_limit,
  output fwrl_pkg::dec_t                dec
);

  logic [fwrl_pkg::TS_W-1:0] elapsed;
  logic                      expired;

  assign elapsed = now - entry.start;
  assign expired = elapsed > {1'b0, window_ticks};

  always_comb begin
    dec.write       = 1'b0;
    dec.allowed     = 1'b0;
    dec.new_window  = 1'b0;
    dec.entry.count = entry.count;
    dec.entry.start = entry.start;
    if ((entry.count == '0) || expired) begin
      dec.write       = 1'b1;
      dec.allowed     = 1'b1;
      dec.new_window  = 1'b1;
      dec.entry.count = fwrl_pkg::LIMIT_W'(1);
      dec.entry.start = now;
    end else if (entry.count < request_limit) begin
      dec.write       = 1'b1;
      dec.allowed     = 1'b1;
      dec.entry.count = entry.count + fwrl_pkg::LIMIT_W'(1);
    end
  end

endmodule
